FILE: rtl/ptle_pkg.sv
// ----------------------------------------------------------------------------
// ptle_pkg
// Types and constants for the pattern-then-literal string extractor.
// ----------------------------------------------------------------------------
package ptle_pkg;

    localparam int LEN_W       = 5;
    localparam int CNT_W       = 5;
    localparam int PAT_BYTES   = 16;
    localparam int PAT_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

    localparam logic [7:0] CHAR_CLOSE  = 8'h29;  // ')'
    localparam logic [7:0] CHAR_ESCAPE = 8'h5C;  // backslash

    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_EOF   = 2'd2;

    localparam logic [1:0] CFG_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_PAT_LOW = 2'd1;
    localparam logic [1:0] CFG_PAT_HI  = 2'd2;

    typedef logic [PAT_BYTES-1:0][7:0] pat_t;

    // Results caused by one input byte: an optional text/close result,
    // then an optional end-of-input result.
    typedef struct packed {
        logic       has_first;
        logic [1:0] first_kind;
        logic [7:0] text;
        logic       has_eof;
    } q_entry_t;

endpackage

FILE: rtl/ptle_front.sv
// ----------------------------------------------------------------------------
// ptle_front
// Accepts bytes, runs the window match and the string scanner, and turns
// each byte that causes a result into a queue entry describing its results.
// ----------------------------------------------------------------------------
module ptle_front
    import ptle_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output logic             in_ready,
    input  logic [LEN_W-1:0] used_len,
    input  pat_t             pattern,
    input  logic             q_full,
    output logic             q_push,
    output q_entry_t         q_entry
);

    typedef enum logic [1:0] {
        MODE_SEARCH,
        MODE_STRING,
        MODE_ESCAPE
    } mode_t;

    mode_t                            mode_reg, mode_next;
    logic [MAX_PATTERN-1:0][7:0]      window_reg, window_next;
    logic [CNT_W-1:0]                 count_reg, count_next;

    logic             accept;
    logic             hit;
    logic             count_ok;
    logic [LEN_W-1:0] len_m1;
    logic [LEN_W-1:0] len_m2;
    logic [LEN_W-1:0] sel;
    q_entry_t         entry;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign len_m1   = used_len - LEN_W'(1);
    assign len_m2   = used_len - LEN_W'(2);
    assign count_ok = ({1'b0, count_reg} + (CNT_W+1)'(1)) >= (CNT_W+1)'(used_len);

    // Window compare: entry k (newest first) must equal pattern byte len-2-k.
    always_comb begin
        hit = count_ok && (in_byte == pattern[len_m1[PAT_IDX_W-1:0]]);
        sel = '0;
        for (int k = 0; k < MAX_PATTERN - 1; k++) begin
            sel = len_m2 - LEN_W'(k);
            if ((LEN_W'(k) + LEN_W'(1)) < used_len &&
                window_reg[k] != pattern[sel[PAT_IDX_W-1:0]]) begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        window_next = window_reg;
        count_next  = count_reg;
        entry.has_first  = 1'b0;
        entry.first_kind = KIND_TEXT;
        entry.text       = 8'h00;
        entry.has_eof    = in_last;
        case (mode_reg)
            MODE_STRING: begin
                if (in_byte == CHAR_ESCAPE) begin
                    mode_next = MODE_ESCAPE;
                end else if (in_byte == CHAR_CLOSE) begin
                    entry.has_first  = 1'b1;
                    entry.first_kind = KIND_CLOSE;
                    mode_next   = MODE_SEARCH;
                    window_next = '0;
                    count_next  = '0;
                end else begin
                    entry.has_first = 1'b1;
                    entry.text      = in_byte;
                end
            end
            MODE_ESCAPE: begin
                entry.has_first = 1'b1;
                entry.text      = in_byte;
                mode_next       = MODE_STRING;
            end
            default: begin
                window_next = {window_reg[MAX_PATTERN-2:0], in_byte};
                if (count_reg != CNT_MAX) count_next = count_reg + CNT_W'(1);
                if (hit) begin
                    mode_next  = MODE_STRING;
                    count_next = '0;
                end
            end
        endcase
        if (in_last) begin
            mode_next   = MODE_SEARCH;
            window_next = '0;
            count_next  = '0;
        end
    end

    assign q_entry = entry;
    assign q_push  = accept && (entry.has_first || entry.has_eof);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_SEARCH;
            window_reg <= '0;
            count_reg  <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/ptle_queue.sv
// ----------------------------------------------------------------------------
// ptle_queue
// Short register queue of result entries between front and back.
// ----------------------------------------------------------------------------
module ptle_queue
    import ptle_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t head,
    output logic     empty,
    output logic     full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    q_entry_t               store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]         count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head  = store_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + (PTR_W+1)'(1);
        if (!push && pop) count_next = count_reg - (PTR_W+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) store_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/ptle_back.sv
// ----------------------------------------------------------------------------
// ptle_back
// Expands each queue entry into one or two result transfers.
// ----------------------------------------------------------------------------
module ptle_back
    import ptle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  q_entry_t   head,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       out_valid,
    output logic [7:0] out_text,
    output logic [1:0] out_kind,
    input  logic       out_ready
);

    logic first_done_reg, first_done_next;
    logic show_first;
    logic xfer;

    assign out_valid  = !q_empty;
    assign show_first = head.has_first && !first_done_reg;
    assign out_kind   = show_first ? head.first_kind : KIND_EOF;
    assign out_text   = show_first ? head.text : 8'h00;
    assign xfer       = out_valid && out_ready;
    // entry is finished once its last result is transferred
    assign q_pop      = xfer && !(show_first && head.has_eof);

    always_comb begin
        first_done_next = first_done_reg;
        if (xfer) first_done_next = !q_pop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_done_reg <= 1'b0;
        end else begin
            first_done_reg <= first_done_next;
        end
    end

endmodule

FILE: rtl/pattern_then_literal_string_extractor_core.sv
// ----------------------------------------------------------------------------
// pattern_then_literal_string_extractor_core
// Searches a byte stream for a start pattern and extracts the escaped
// string after it, closed by ')' or by the end of input.
// ----------------------------------------------------------------------------
// Each byte's results are written to the result queue when it is transferred in.
// Throughput: one byte per cycle while the result queue is not full, with a
// combinational window compare; bytes that cause two results need two output
// transfers, absorbed by the four-entry result queue.
// Reset: synchronous, active low; clears scanner state, queue and config
// registers (length 1, pattern bytes zero).
module pattern_then_literal_string_extractor_core
    import ptle_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] text_byte
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [LEN_W-1:0] len_reg;
    logic [63:0]      pat_lo_reg;
    logic [63:0]      pat_hi_reg;
    logic [LEN_W-1:0] used_len;
    pat_t             pattern;

    logic     q_push, q_pop, q_empty, q_full;
    q_entry_t q_entry, q_head;

    assign cfg_ready = 1'b1;
    assign pattern   = {pat_hi_reg, pat_lo_reg};

    always_comb begin
        used_len = len_reg;
        if (len_reg == '0) used_len = LEN_W'(1);
        if (len_reg > LEN_W'(MAX_PATTERN)) used_len = LEN_W'(MAX_PATTERN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= LEN_W'(1);
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LENGTH:  len_reg    <= cfg_data[LEN_W-1:0];
                CFG_PAT_LOW: pat_lo_reg <= cfg_data;
                CFG_PAT_HI:  pat_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ptle_front #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .used_len (used_len),
        .pattern  (pattern),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    ptle_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    ptle_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_text  (m_tdata),
        .out_kind  (m_tuser),
        .out_ready (m_tready)
    );

`ifndef ASSERT_OFF
    // an empty result side means the queue has room
    a_ready_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result queue");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("illegal result kind");

    a_text_only_for_text: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_TEXT) |-> (m_tdata == 8'h00))
        else $error("non-text result carries data");

    // a byte accepted into an empty path must show a result or nothing next cycle,
    // never leave the queue full
    a_no_full_after_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && s_tvalid) |=> s_tready)
        else $error("queue full after one entry");
`endif

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pattern-then-literal string extractor. A
// scoreboard keeps its own model of the pattern window, string and escape
// states and the register set, predicts the results of every byte
// transferred in, and checks each result transferred out in order.
// Stimulus is a directed run through the escape, close and end-of-input
// corners, then random records (noise, start pattern, escaped body, close)
// under several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top
    import ptle_pkg::*;
();

    localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped index, write ignored
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 180;

    typedef enum logic [1:0] {
        SCAN_SEARCH = 2'd0,
        SCAN_STRING = 2'd1,
        SCAN_ESCAPE = 2'd2
    } scan_mode_e;

    typedef struct {
        logic [7:0] text;
        logic [1:0] kind;
    } extract_result_t;

    class extract_scoreboard;
        logic [4:0]      pat_len;
        logic [63:0]     pat_lo;
        logic [63:0]     pat_hi;
        logic [7:0]      window [PAT_BYTES-1];
        logic [4:0]      seen;
        scan_mode_e      mode;
        extract_result_t expected_q[$];
        int              errors;

        function new();
            pat_len = 5'd1;
            pat_lo  = '0;
            pat_hi  = '0;
            errors  = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (window[k]) window[k] = 8'h00;
            seen = '0;
            mode = SCAN_SEARCH;
        endfunction

        function int used_len();
            int n;
            n = pat_len;
            if (n == 0) n = 1;
            if (n > PAT_BYTES) n = PAT_BYTES;
            return n;
        endfunction

        function logic [7:0] pat_byte(int i);
            return (i < 8) ? pat_lo[i*8 +: 8] : pat_hi[(i-8)*8 +: 8];
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                CFG_LENGTH:  pat_len = val[4:0];
                CFG_PAT_LOW: pat_lo  = val;
                CFG_PAT_HI:  pat_hi  = val;
                default: ;
            endcase
        endfunction

        // Shift the byte into the window; report whether it completes the pattern
        function bit window_hit(logic [7:0] c);
            int len;
            bit hit;
            len = used_len();
            hit = 1'b0;
            if (int'(seen) + 1 >= len && c == pat_byte(len - 1)) begin
                hit = 1'b1;
                for (int k = 0; k + 1 < len; k++)
                    if (window[k] != pat_byte(len - 2 - k)) hit = 1'b0;
            end
            for (int k = PAT_BYTES - 2; k > 0; k--) window[k] = window[k-1];
            window[0] = c;
            if (seen != CNT_MAX) seen++;
            return hit;
        endfunction

        function void push(logic [7:0] text, logic [1:0] kind);
            extract_result_t r;
            r.text = text;
            r.kind = kind;
            expected_q.push_back(r);
        endfunction

        function void take_byte(logic [7:0] c, logic fin);
            case (mode)
                SCAN_STRING: begin
                    if (c == CHAR_ESCAPE) begin
                        mode = SCAN_ESCAPE;
                    end else if (c == CHAR_CLOSE) begin
                        push(8'h00, KIND_CLOSE);
                        clear_scan();
                    end else begin
                        push(c, KIND_TEXT);
                    end
                end
                SCAN_ESCAPE: begin
                    push(c, KIND_TEXT);
                    mode = SCAN_STRING;
                end
                default: begin
                    if (window_hit(c)) begin
                        mode = SCAN_STRING;
                        seen = '0;
                    end
                end
            endcase
            if (fin) begin
                push(8'h00, KIND_EOF);
                clear_scan();
            end
        endfunction

        function void check_result(logic [7:0] text, logic [1:0] kind);
            extract_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual text=%02h kind=%0d",
                         $time, text, kind);
                return;
            end
            e = expected_q.pop_front();
            if (text !== e.text) begin
                errors++;
                $display("%0t: text_byte mismatch: expected %02h, actual %02h",
                         $time, e.text, text);
            end
            if (kind !== e.kind) begin
                errors++;
                $display("%0t: result_kind mismatch: expected %0d, actual %0d",
                         $time, e.kind, kind);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [63:0] cfg_data  = '0;

    extract_scoreboard sb = new();
    int send_idle  = 0;
    int recv_stall = 0;
    int items_sent = 0;

    pattern_then_literal_string_extractor_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Both sides sampled at the same edge, before any of this edge's updates land
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        end
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Leaves cfg_valid high; caller drops it after the last write
    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_pattern(input logic [4:0] len, input logic [63:0] lo,
                               input logic [63:0] hi);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_write(CFG_LENGTH, {junk[63:5], len});
        cfg_write(CFG_PAT_LOW, lo);
        cfg_write(CFG_PAT_HI, hi);
        cfg_write(CFG_SPARE, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic rare_final();
        return ($urandom_range(199) == 0);
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(1)) return sb.pat_byte($urandom_range(sb.used_len() - 1));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] body_byte();
        int r;
        r = $urandom_range(99);
        if (r < 12) return CHAR_ESCAPE;
        if (r < 18) return CHAR_CLOSE;
        return 8'($urandom_range(255));
    endfunction

    // Noise, start pattern (sometimes cut short), string body, usually a close
    task automatic send_record();
        int plen;
        bit broken;
        plen   = sb.used_len();
        broken = ($urandom_range(99) < 15);
        repeat ($urandom_range(5)) send_byte(noise_byte(), rare_final());
        for (int i = 0; i < plen - int'(broken); i++) send_byte(sb.pat_byte(i), 1'b0);
        repeat ($urandom_range(8)) send_byte(body_byte(), rare_final());
        if ($urandom_range(99) < 75)
            send_byte(CHAR_CLOSE, rare_final());
        else if ($urandom_range(1))
            send_byte(body_byte(), 1'b1);
    endtask

    initial begin
        int start;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: pattern "x(" then escapes, closes and end-of-input corners
        set_pattern(5'd2, 64'h2878, 64'h0);
        send_byte(8'h00, 1'b0);
        send_byte("x", 1'b0);
        send_byte("(", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CHAR_ESCAPE, 1'b0);
        send_byte(CHAR_CLOSE, 1'b0);   // escaped close is text
        send_byte(CHAR_ESCAPE, 1'b0);
        send_byte(CHAR_ESCAPE, 1'b0);  // escaped backslash is text
        send_byte(CHAR_CLOSE, 1'b0);
        send_byte("x", 1'b0);
        send_byte("(", 1'b0);
        send_byte("A", 1'b0);
        send_byte(CHAR_ESCAPE, 1'b1);  // backslash on final byte: end of input only
        send_byte("x", 1'b0);
        send_byte("(", 1'b0);
        send_byte(CHAR_CLOSE, 1'b1);   // close and end of input together
        send_byte("x", 1'b0);
        send_byte("(", 1'b1);          // match on final byte
        send_byte(8'hFF, 1'b1);        // end of input while searching
        send_byte("x", 1'b0);
        send_byte("(", 1'b0);
        send_byte(CHAR_ESCAPE, 1'b0);
        send_byte("A", 1'b1);          // escaped byte on final byte
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_pattern(5'd1, {$urandom, $urandom}, {$urandom, $urandom});
                1: set_pattern(5'd16, {$urandom, $urandom}, {$urandom, $urandom});
                2: set_pattern(5'd0, {$urandom, $urandom}, {$urandom, $urandom});
                3: set_pattern(5'd31, '1, '1);
                4: set_pattern(5'd5, {$urandom, $urandom}, {$urandom, $urandom});
                5: set_pattern(5'd9, {$urandom, $urandom}, {$urandom, $urandom});
                6: set_pattern(5'd2, 64'h6161, '0);  // self-overlapping pattern
                default: set_pattern(5'($urandom_range(1, 16)),
                                     {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 87; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 87; end
                default: begin send_idle = 29; recv_stall = 29; end
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) send_record();
            drain();
        end

        repeat (4) @(posedge aclk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: pattern_then_literal_string_extractor_core.f
rtl/ptle_pkg.sv
rtl/ptle_front.sv
rtl/ptle_queue.sv
rtl/ptle_back.sv
rtl/pattern_then_literal_string_extractor_core.sv
tb/tb_top.sv
